FILE: rtl/core/alarm_snooze_sequencer_assert.svh
// Assertion macros shared by the alarm snooze sequencer RTL.
// Each macro takes a label, a clock, a reset and the expressions to check.
`ifndef ALARM_SNOOZE_SEQUENCER_ASSERT_SVH
`define ALARM_SNOOZE_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASEQ_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("alarm snooze sequencer check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASEQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("alarm snooze sequencer check failed");

`endif

FILE: rtl/core/asseq_pkg.sv
// Package for the alarm snooze sequencer: field widths, register indexes,
// reset values, the structs passed between modules and the snooze time helper.
// No dependencies.
`default_nettype none

package asseq_pkg;

   localparam int HOUR_W      = 5;
   localparam int MINUTE_W    = 6;
   localparam int SECOND_W    = 6;
   localparam int SNOOZE_W    = 5;
   localparam int TIMEOUT_W   = 16;
   localparam int LED_W       = 10;
   localparam int PHASE_W     = 2;
   localparam int COUNT_W     = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_HOUR   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_MINUTE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_24_HOUR  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SNOOZE_MIN   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RING_TIMEOUT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LED_PERIOD   = 3'd5;

   localparam logic [HOUR_W-1:0]    RST_ALARM_HOUR   = 5'd12;
   localparam logic [MINUTE_W-1:0]  RST_ALARM_MINUTE = 6'd0;
   localparam logic                 RST_USE_24_HOUR  = 1'b0;
   localparam logic [SNOOZE_W-1:0]  RST_SNOOZE_MIN   = 5'd5;
   localparam logic [TIMEOUT_W-1:0] RST_RING_TIMEOUT = 16'd60000;
   localparam logic [LED_W-1:0]     RST_LED_PERIOD   = 10'd300;

   localparam logic [MINUTE_W:0] LAST_MINUTE      = 7'd59;
   localparam logic [MINUTE_W:0] MINUTES_PER_HOUR = 7'd60;
   localparam logic [HOUR_W-1:0] HOUR_NOON        = 5'd12;
   localparam logic [HOUR_W-1:0] HOUR_LAST        = 5'd23;
   localparam logic [HOUR_W-1:0] HOUR_ONE         = 5'd1;

   typedef struct packed {
      logic [HOUR_W-1:0]    alarm_hour;
      logic [MINUTE_W-1:0]  alarm_minute;
      logic                 use_24_hour;
      logic [SNOOZE_W-1:0]  snooze_minutes;
      logic [TIMEOUT_W-1:0] ring_timeout;
      logic [LED_W-1:0]     led_period;
   } cfg_type;

   // A classified tick item as it travels from the front to the back.
   typedef struct packed {
      logic                start;
      logic                dismiss;
      logic                time_mark;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
   } cmd_type;

   typedef struct packed {
      logic               buzzer_on;
      logic [PHASE_W-1:0] phase;
      logic [COUNT_W-1:0] rings_done;
      logic               led_phase;
      logic               finished;
      logic               snooze_hit;
   } rsp_type;

   typedef struct packed {
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
   } clock_time_type;

   // Adds a number of minutes to the alarm time. The minute wraps at most once
   // and the hour then steps once with the wrap of the selected hour format.
   function automatic clock_time_type advance_time(
      input logic [HOUR_W-1:0]   hour,
      input logic [MINUTE_W-1:0] minute,
      input logic                use_24_hour,
      input logic [MINUTE_W:0]   add
   );
      logic [MINUTE_W:0] sum;
      clock_time_type    t;
      sum      = {1'b0, minute} + add;
      t.hour   = hour;
      t.minute = sum[MINUTE_W-1:0];
      if (sum > LAST_MINUTE) begin
         t.minute = MINUTE_W'(sum - MINUTES_PER_HOUR);
         if (use_24_hour) begin
            t.hour = (hour == HOUR_LAST) ? '0 : hour + HOUR_ONE;
         end else begin
            t.hour = (hour == HOUR_NOON) ? HOUR_ONE : hour + HOUR_ONE;
         end
      end
      return t;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/asseq_fifo.sv
// Small register queue with separate push and pop sides.
// Generic in width and depth; no package dependency.
`default_nettype none

module asseq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = data_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/asseq_front.sv
// Front end of the alarm snooze sequencer: takes tick items and classifies them.
// Depends on asseq_pkg for the command struct and field widths.
`default_nettype none

module asseq_front (
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic                          start_req,
   input  wire logic                          dismiss_press,
   input  wire logic                          time_valid,
   input  wire logic [asseq_pkg::HOUR_W-1:0]   now_hour,
   input  wire logic [asseq_pkg::MINUTE_W-1:0] now_minute,
   input  wire logic [asseq_pkg::SECOND_W-1:0] now_second,
   input  wire logic                          cmd_full,
   output logic                               cmd_push,
   output asseq_pkg::cmd_type                 cmd
);

   assign req_full = cmd_full;
   assign cmd_push = req_push && !cmd_full;

   // Only a fresh time stamp on a whole minute can match a snooze target,
   // so the seconds are reduced to a single flag here.
   always_comb begin
      cmd.start     = start_req;
      cmd.dismiss   = dismiss_press;
      cmd.time_mark = time_valid && (now_second == '0);
      cmd.hour      = now_hour;
      cmd.minute    = now_minute;
   end

endmodule

`default_nettype wire

FILE: rtl/core/asseq_back.sv
// Back end of the alarm snooze sequencer: ring, snooze and LED state machine.
// Depends on asseq_pkg and the assertion macros in alarm_snooze_sequencer_assert.svh.
`default_nettype none
`include "alarm_snooze_sequencer_assert.svh"

module asseq_back #(
   parameter int RING_TIMER_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire asseq_pkg::cfg_type cfg,
   input  wire logic               cmd_valid,
   input  wire asseq_pkg::cmd_type cmd,
   output logic                    cmd_pop,
   input  wire logic               rsp_full,
   output logic                    rsp_push,
   output asseq_pkg::rsp_type      rsp
);

   localparam int T     = RING_TIMER_BITS;
   localparam int CMP_W = (T > asseq_pkg::TIMEOUT_W) ? T : asseq_pkg::TIMEOUT_W;
   localparam int LW    = asseq_pkg::LED_W;
   localparam int CNT_W = asseq_pkg::COUNT_W;

   typedef enum logic [asseq_pkg::PHASE_W-1:0] {
      PH_IDLE = 2'd0,
      PH_RING = 2'd1,
      PH_WAIT = 2'd2
   } phase_type;

   phase_type                   phase_ff, phase_in, cur_phase;
   logic [CNT_W-1:0]            count_ff, count_in, cur_count;
   logic [T-1:0]                timer_ff, timer_in, cur_timer, timer_inc;
   logic [LW-1:0]               led_timer_ff, led_timer_in, cur_led;
   logic [LW:0]                 led_inc;
   logic                        toggle_ff, toggle_in;
   asseq_pkg::clock_time_type   first_ff, first_in, second_ff, second_in;
   logic                        step, start_go, ring_end, match, fin, hit;

   assign step     = cmd_valid && !rsp_full;
   assign cmd_pop  = step;
   assign rsp_push = step;
   assign start_go = (phase_ff == PH_IDLE) && cmd.start;

   always_comb begin
      first_in  = asseq_pkg::advance_time(cfg.alarm_hour, cfg.alarm_minute, cfg.use_24_hour,
                                          {2'b00, cfg.snooze_minutes});
      second_in = asseq_pkg::advance_time(cfg.alarm_hour, cfg.alarm_minute, cfg.use_24_hour,
                                          {1'b0, cfg.snooze_minutes, 1'b0});
   end

   always_comb begin
      // A start item is handled as the first ringing tick of a fresh sequence.
      cur_phase = start_go ? PH_RING : phase_ff;
      cur_count = start_go ? '0 : count_ff;
      cur_timer = start_go ? '0 : timer_ff;
      cur_led   = start_go ? '0 : led_timer_ff;

      phase_in     = cur_phase;
      count_in     = cur_count;
      timer_in     = cur_timer;
      led_timer_in = cur_led;
      toggle_in    = toggle_ff;
      fin          = 1'b0;
      hit          = 1'b0;
      ring_end     = 1'b0;
      match        = 1'b0;
      timer_inc    = (cur_timer == {T{1'b1}}) ? cur_timer : cur_timer + T'(1);
      led_inc      = {1'b0, cur_led} + (LW + 1)'(1);

      if (cur_phase != PH_IDLE) begin
         toggle_in    = toggle_ff ^ (cur_led == '0);
         led_timer_in = (led_inc >= {1'b0, cfg.led_period}) ? '0 : led_inc[LW-1:0];
      end

      case (cur_phase)
         PH_RING: begin
            ring_end = (CMP_W'(timer_inc) >= CMP_W'(cfg.ring_timeout)) || cmd.dismiss;
            timer_in = timer_inc;
            if (ring_end) begin
               timer_in = '0;
               count_in = cur_count + CNT_W'(1);
               if (cur_count < CNT_W'(2)) begin
                  phase_in = PH_WAIT;
               end else begin
                  phase_in = PH_IDLE;
                  fin      = 1'b1;
               end
            end
         end
         PH_WAIT: begin
            if (cmd.time_mark) begin
               if (cur_count == CNT_W'(1)) begin
                  match = (cmd.hour == first_ff.hour) && (cmd.minute == first_ff.minute);
               end else if (cur_count == CNT_W'(2)) begin
                  match = (cmd.hour == second_ff.hour) && (cmd.minute == second_ff.minute);
               end
            end
            // A press wins over a snooze match on the same tick.
            if (cmd.dismiss) begin
               phase_in = PH_IDLE;
               fin      = 1'b1;
            end else if (match) begin
               phase_in = PH_RING;
               timer_in = '0;
               hit      = 1'b1;
            end
         end
         default: begin
         end
      endcase

      rsp.buzzer_on  = (phase_in == PH_RING);
      rsp.phase      = phase_in;
      rsp.rings_done = count_in;
      rsp.led_phase  = toggle_in;
      rsp.finished   = fin;
      rsp.snooze_hit = hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         timer_ff     <= '0;
         led_timer_ff <= '0;
         toggle_ff    <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         timer_ff     <= timer_in;
         led_timer_ff <= led_timer_in;
         toggle_ff    <= toggle_in;
      end
   end

   // Snooze targets are only read while waiting, which always follows a start.
   always_ff @(posedge clock) begin
      if (step && start_go) begin
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   `ASEQ_ASSERT_NOW(a_finish_is_idle, clock, reset, rsp_push && rsp.finished, rsp.phase == PH_IDLE)
   `ASEQ_ASSERT_NOW(a_wait_count, clock, reset, phase_ff == PH_WAIT, count_ff == CNT_W'(1) || count_ff == CNT_W'(2))
   `ASEQ_ASSERT_NOW(a_timer_idle_zero, clock, reset, phase_ff != PH_RING, timer_ff == '0)
   `ASEQ_ASSERT_NEXT(a_hit_rings, clock, reset, step && hit, phase_ff == PH_RING)

endmodule

`default_nettype wire

FILE: rtl/core/alarm_snooze_sequencer.sv
// Alarm ring and snooze sequencer. Each item is one millisecond tick; a
// start request rings the alarm and two snooze rings follow at fixed
// intervals unless a short button press dismisses the sequence.
// Items enter on the req_ queue port: one is taken at each rising edge where
// req_push is high and req_full is low. Results leave on the rsp_ queue port:
// the oldest result is shown while rsp_empty is low and is taken at an edge
// where rsp_pop is high. Every item gives exactly one result.
// An item taken waits in the command queue; the back end's result for it is
// written into the result queue, which drives the result ports. One item per
// cycle is sustained while the result queue is not full, set by the back end
// state update, which takes the next command queue item every such cycle.
// When rsp_pop stays low the result queue fills, the back end holds, the
// command queue fills and req_full rises; nothing is lost.
// Configuration registers are written through csr_write, csr_index, csr_wdata;
// the user must write them only while the block is idle (not enforced). Reset
// empties both queues, returns the sequencer to idle and loads the default
// register values. Depends on asseq_pkg, asseq_front, asseq_fifo and asseq_back.
`default_nettype none

module alarm_snooze_sequencer #(
   parameter int RING_TIMER_BITS = 16,
   parameter int CMD_QUEUE_DEPTH = 2,
   parameter int RSP_QUEUE_DEPTH = 2
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write,
   input  wire logic [asseq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [asseq_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire logic                             req_start_req,
   input  wire logic                             req_dismiss_press,
   input  wire logic                             req_time_valid,
   input  wire logic [asseq_pkg::HOUR_W-1:0]      req_now_hour,
   input  wire logic [asseq_pkg::MINUTE_W-1:0]    req_now_minute,
   input  wire logic [asseq_pkg::SECOND_W-1:0]    req_now_second,
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output logic                                  rsp_buzzer_on,
   output logic [asseq_pkg::PHASE_W-1:0]          rsp_phase,
   output logic [asseq_pkg::COUNT_W-1:0]          rsp_rings_done,
   output logic                                  rsp_led_phase,
   output logic                                  rsp_finished,
   output logic                                  rsp_snooze_hit
);

   localparam int CMD_W = $bits(asseq_pkg::cmd_type);
   localparam int RSP_W = $bits(asseq_pkg::rsp_type);

   asseq_pkg::cfg_type cfg_ff;
   asseq_pkg::cmd_type front_cmd, back_cmd;
   asseq_pkg::rsp_type back_rsp, out_rsp;
   logic [CMD_W-1:0]   cmd_rd_data;
   logic [RSP_W-1:0]   rsp_rd_data;
   logic               cmd_push, cmd_full, cmd_empty, cmd_pop;
   logic               rsp_push, rsp_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alarm_hour     <= asseq_pkg::RST_ALARM_HOUR;
         cfg_ff.alarm_minute   <= asseq_pkg::RST_ALARM_MINUTE;
         cfg_ff.use_24_hour    <= asseq_pkg::RST_USE_24_HOUR;
         cfg_ff.snooze_minutes <= asseq_pkg::RST_SNOOZE_MIN;
         cfg_ff.ring_timeout   <= asseq_pkg::RST_RING_TIMEOUT;
         cfg_ff.led_period     <= asseq_pkg::RST_LED_PERIOD;
      end else if (csr_write) begin
         case (csr_index)
            asseq_pkg::CSR_ALARM_HOUR: begin
               cfg_ff.alarm_hour <= csr_wdata[asseq_pkg::HOUR_W-1:0];
            end
            asseq_pkg::CSR_ALARM_MINUTE: begin
               cfg_ff.alarm_minute <= csr_wdata[asseq_pkg::MINUTE_W-1:0];
            end
            asseq_pkg::CSR_USE_24_HOUR: begin
               cfg_ff.use_24_hour <= csr_wdata[0];
            end
            asseq_pkg::CSR_SNOOZE_MIN: begin
               cfg_ff.snooze_minutes <= csr_wdata[asseq_pkg::SNOOZE_W-1:0];
            end
            asseq_pkg::CSR_RING_TIMEOUT: begin
               cfg_ff.ring_timeout <= csr_wdata[asseq_pkg::TIMEOUT_W-1:0];
            end
            asseq_pkg::CSR_LED_PERIOD: begin
               cfg_ff.led_period <= csr_wdata[asseq_pkg::LED_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   asseq_front u_front (
      .req_push      (req_push),
      .req_full      (req_full),
      .start_req     (req_start_req),
      .dismiss_press (req_dismiss_press),
      .time_valid    (req_time_valid),
      .now_hour      (req_now_hour),
      .now_minute    (req_now_minute),
      .now_second    (req_now_second),
      .cmd_full      (cmd_full),
      .cmd_push      (cmd_push),
      .cmd           (front_cmd)
   );

   asseq_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (front_cmd),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd_data),
      .empty   (cmd_empty)
   );

   assign back_cmd = asseq_pkg::cmd_type'(cmd_rd_data);

   asseq_back #(
      .RING_TIMER_BITS (RING_TIMER_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (!cmd_empty),
      .cmd       (back_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (back_rsp)
   );

   asseq_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_rd_data),
      .empty   (rsp_empty)
   );

   assign out_rsp        = asseq_pkg::rsp_type'(rsp_rd_data);
   assign rsp_buzzer_on  = out_rsp.buzzer_on;
   assign rsp_phase      = out_rsp.phase;
   assign rsp_rings_done = out_rsp.rings_done;
   assign rsp_led_phase  = out_rsp.led_phase;
   assign rsp_finished   = out_rsp.finished;
   assign rsp_snooze_hit = out_rsp.snooze_hit;

endmodule

`default_nettype wire
